>>> rtl/dst_pkg.sv
// dst_pkg: shared types and constants for the descriptor slot table.
// Request and status codes, the packed slot entry, reset defaults.
// No dependencies.
package dst_pkg;

    localparam int DST_SLOTS_DEFAULT = 64;
    localparam int DST_STD_STREAMS   = 3;

    localparam logic [2:0] KIND_STANDARD = 3'd1;

    typedef enum logic [1:0] {
        REQ_ALLOC       = 2'd0,
        REQ_FREE        = 2'd1,
        REQ_HOST_LOOKUP = 2'd2,
        REQ_SLOT_LOOKUP = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_NO_ROOM   = 2'd2
    } status_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [15:0] host;
        logic [31:0] flags;
    } entry_t;

endpackage

>>> rtl/descriptor_slot_table_core.sv
// descriptor_slot_table_core: descriptor slot table with sequencer and scan.
// Depends on dst_pkg, dst_entry_ram, dst_match_unit.
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  request | s_valid/s_ready, s_req_type..flags | in
//  result  | m_valid/m_ready, m_status..type    | out
//
// Named allocate, or any request on a slot beyond the table: result straight from S_DONE.
// Free and host lookup: one RAM read in S_READ, then S_DONE.
// Lowest-free allocate and handle search: S_SCAN walks the table, one entry per
// cycle through the RAM read port and the compare unit.
// After reset a fill pass in S_CLEAR loads every slot of the table; s_ready stays low.
// A result waiting on m_ready does not block the next request from being taken.
module descriptor_slot_table_core
    import dst_pkg::*;
#(
    parameter int SLOTS = DST_SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic        s_pick_lowest,
    input  logic [5:0]  s_guest_slot,
    input  logic [15:0] s_host_handle,
    input  logic [2:0]  s_desc_type,
    input  logic [31:0] s_entry_flags,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_slot_out,
    output logic [15:0] m_host_out,
    output logic [2:0]  m_type_out
);

    localparam int            IW   = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [IW-1:0] cnt_reg;
    logic [IW-1:0] pidx_reg;
    logic          pend_reg;
    req_t          req_reg;
    logic [IW-1:0] slot_reg;
    logic [15:0]   host_reg;
    logic [2:0]    kind_reg;
    logic [31:0]   flags_reg;

    status_t       res_status_reg;
    logic [5:0]    res_slot_reg;
    logic [15:0]   res_host_reg;
    logic [2:0]    res_type_reg;

    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic [5:0]    m_slot_reg;
    logic [15:0]   m_host_reg;
    logic [2:0]    m_type_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic [IW-1:0] rd_addr;
    entry_t        rd_data;
    logic          hit;
    logic          in_range;
    logic          std_slot;
    req_t          s_req;

    assign s_req    = req_t'(s_req_type);
    assign in_range = 32'(s_guest_slot) < 32'(SLOTS);
    assign std_slot = 32'(cnt_reg) < 32'(DST_STD_STREAMS);

    dst_entry_ram #(
        .SLOTS(SLOTS)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    dst_match_unit u_match (
        .entry    (rd_data),
        .find_free(req_reg == REQ_ALLOC),
        .key      (host_reg),
        .hit      (hit)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        rd_addr = cnt_reg;
        case (state_reg)
            S_CLEAR: begin
                wr_en         = 1'b1;
                wr_data.valid = std_slot;
                wr_data.host  = std_slot ? 16'(cnt_reg) : 16'd0;
                wr_data.kind  = std_slot ? KIND_STANDARD : 3'd0;
            end
            S_IDLE: begin
                rd_addr = IW'(s_guest_slot);
                if (s_valid && s_req == REQ_ALLOC && !s_pick_lowest && in_range) begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(s_guest_slot);
                    wr_data = '{valid: 1'b1, kind: s_desc_type, host: s_host_handle,
                                flags: s_entry_flags};
                end
            end
            S_READ: begin
                if (req_reg == REQ_FREE && rd_data.valid) begin
                    wr_en   = 1'b1;
                    wr_addr = slot_reg;
                end
            end
            S_SCAN: begin
                if (pend_reg && hit && req_reg == REQ_ALLOC) begin
                    wr_en   = 1'b1;
                    wr_addr = pidx_reg;
                    wr_data = '{valid: 1'b1, kind: kind_reg, host: host_reg, flags: flags_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    if (cnt_reg == LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_req;
                        slot_reg  <= IW'(s_guest_slot);
                        host_reg  <= s_host_handle;
                        kind_reg  <= s_desc_type;
                        flags_reg <= s_entry_flags;
                        cnt_reg   <= '0;
                        pend_reg  <= 1'b0;
                        if (s_req == REQ_ALLOC && !s_pick_lowest && in_range) begin
                            res_status_reg <= STATUS_OK;
                            res_slot_reg   <= s_guest_slot;
                            res_host_reg   <= s_host_handle;
                            res_type_reg   <= s_desc_type;
                        end else begin
                            res_status_reg <= (s_req == REQ_ALLOC && !s_pick_lowest)
                                              ? STATUS_NO_ROOM : STATUS_NOT_FOUND;
                            res_slot_reg   <= '0;
                            res_host_reg   <= '0;
                            res_type_reg   <= '0;
                        end
                        case (s_req)
                            REQ_ALLOC: begin
                                state_reg <= s_pick_lowest ? S_SCAN : S_DONE;
                            end
                            REQ_FREE, REQ_HOST_LOOKUP: begin
                                state_reg <= in_range ? S_READ : S_DONE;
                            end
                            REQ_SLOT_LOOKUP: begin
                                state_reg <= S_SCAN;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (rd_data.valid) begin
                        res_status_reg <= STATUS_OK;
                        res_host_reg   <= rd_data.host;
                        res_type_reg   <= rd_data.kind;
                    end
                    state_reg <= S_DONE;
                end
                S_SCAN: begin
                    pend_reg <= 1'b1;
                    pidx_reg <= cnt_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (pend_reg && hit) begin
                        res_status_reg <= STATUS_OK;
                        res_slot_reg   <= 6'(pidx_reg);
                        res_host_reg   <= host_reg;
                        res_type_reg   <= (req_reg == REQ_ALLOC) ? kind_reg : rd_data.kind;
                        state_reg      <= S_DONE;
                    end else if (pend_reg && pidx_reg == LAST) begin
                        res_status_reg <= (req_reg == REQ_ALLOC) ? STATUS_NO_ROOM
                                                                 : STATUS_NOT_FOUND;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_host_reg   <= res_host_reg;
                        m_type_reg   <= res_type_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_slot_out = m_slot_reg;
    assign m_host_out = m_host_reg;
    assign m_type_out = m_type_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous item in flight");

    a_result_not_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result loaded in the cycle a request was taken");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |->
            (m_slot_out == 6'd0 && m_host_out == 16'd0 && m_type_out == 3'd0))
        else $error("failed request carries nonzero result fields");

endmodule

>>> rtl/dst_entry_ram.sv
// dst_entry_ram: slot entry storage, one write port and one registered read port.
// Depends on dst_pkg (entry_t).
module dst_entry_ram
    import dst_pkg::*;
#(
    parameter int SLOTS = DST_SLOTS_DEFAULT,
    localparam int IW   = $clog2(SLOTS)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dst_match_unit.sv
// dst_match_unit: per-entry compare shared by the free-slot and handle scans.
// Depends on dst_pkg (entry_t).
module dst_match_unit
    import dst_pkg::*;
(
    input  entry_t      entry,
    input  logic        find_free,
    input  logic [15:0] key,
    output logic        hit
);

    always_comb begin
        if (find_free) begin
            hit = ~entry.valid;
        end else begin
            hit = entry.valid && (entry.host == key);
        end
    end

endmodule
